/* sv/sorted_timer_event_queue_top_assert.svh */
// Assertion helpers for the timer queue checker.
`ifndef SORTED_TIMER_EVENT_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define STEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/steq_pkg.sv */
package steq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_DEL  = 3'd2;
  localparam logic [2:0] OP_MOD  = 3'd3;
  localparam logic [2:0] OP_LOAD = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] dl;
  } entry_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [31:0] dl;
    logic [31:0] now;
    logic        resched;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       fired_valid;
    logic [7:0] fired_id;
    logic [1:0] status;
    logic       resched;
    logic       last;
  } res_t;

endpackage

/* sv/steq_mem.sv */
module steq_mem #(
  parameter int DEPTH = steq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  steq_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output steq_pkg::entry_t         rdata
);
  import steq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/steq_ctrl.sv */
module steq_ctrl #(
  parameter int DEPTH = steq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  steq_pkg::cmd_t           cmd,
  output logic                     busy,
  output steq_pkg::res_t           res,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output steq_pkg::entry_t         mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  steq_pkg::entry_t         mem_rdata
);
  import steq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_INS  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ridx_r, ridx_nxt;
  logic [CW-1:0] widx_r, widx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          pvld_r, pvld_nxt;
  logic          found_r, found_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    pend_id_r, pend_id_nxt;
  res_t          res_r, res_nxt;

  logic          is_tick;
  logic          le;
  logic [31:0]   cmp_b;
  logic [CW-1:0] rm1;
  logic          issue;

  assign is_tick = (cmd_r.op == OP_TICK);
  // shared comparator: expiry test on tick, slot search on insert
  assign cmp_b   = is_tick ? cmd_r.now : cmd_r.dl;
  assign le      = (mem_rdata.dl <= cmp_b);
  assign rm1     = ridx_r - CW'(1);
  assign issue   = (ridx_r != '0);

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    cnt_nxt     = cnt_r;
    ridx_nxt    = ridx_r;
    widx_nxt    = widx_r;
    pidx_nxt    = pidx_r;
    pvld_nxt    = pvld_r;
    found_nxt   = found_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    res_nxt     = '0;
    mem_we      = 1'b0;
    mem_waddr   = widx_r[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = ridx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd_nxt   = cmd;
          ridx_nxt  = '0;
          widx_nxt  = '0;
          pvld_nxt  = 1'b0;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          if (cmd.op == OP_TICK || cmd.op == OP_ADD || cmd.op == OP_DEL ||
              cmd.op == OP_MOD) begin
            state_nxt = S_SCAN;
          end else begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
          end
        end
      end

      S_SCAN: begin
        // forward compaction: read one ahead, write kept words behind
        if (ridx_r < cnt_r) begin
          ridx_nxt = ridx_r + CW'(1);
          pvld_nxt = 1'b1;
        end else begin
          pvld_nxt = 1'b0;
        end
        if (pvld_r) begin
          if (is_tick && le) begin
            if (pend_r) begin
              res_nxt.valid       = 1'b1;
              res_nxt.fired_valid = 1'b1;
              res_nxt.fired_id    = pend_id_r;
              res_nxt.status      = ST_OK;
              res_nxt.resched     = cmd_r.resched;
            end
            pend_nxt    = 1'b1;
            pend_id_nxt = mem_rdata.id;
          end else if (!is_tick && !found_r && mem_rdata.id == cmd_r.id) begin
            found_nxt = 1'b1;
          end else begin
            mem_we   = 1'b1;
            widx_nxt = widx_r + CW'(1);
          end
        end else if (ridx_r == cnt_r) begin
          if (is_tick) begin
            cnt_nxt             = widx_r;
            res_nxt.valid       = 1'b1;
            res_nxt.fired_valid = pend_r;
            res_nxt.fired_id    = pend_r ? pend_id_r : 8'd0;
            res_nxt.status      = ST_OK;
            res_nxt.resched     = cmd_r.resched;
            res_nxt.last        = 1'b1;
            state_nxt           = S_IDLE;
          end else if (cmd_r.op == OP_DEL) begin
            cnt_nxt        = widx_r;
            res_nxt.valid  = 1'b1;
            res_nxt.status = found_r ? ST_OK : ST_NOTFOUND;
            res_nxt.last   = 1'b1;
            state_nxt      = S_IDLE;
          end else if (!found_r && cnt_r == CW'(DEPTH)) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_FULL;
            res_nxt.last   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cnt_nxt   = widx_r;
            ridx_nxt  = widx_r;
            pvld_nxt  = 1'b0;
            state_nxt = S_INS;
          end
        end
      end

      S_INS: begin
        // walk down from the tail, shifting later deadlines up by one
        mem_raddr = rm1[AW-1:0];
        pvld_nxt  = issue;
        if (issue) begin
          ridx_nxt = rm1;
          pidx_nxt = rm1[AW-1:0];
        end
        if (pvld_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r + AW'(1);
          if (le) begin
            mem_wdata.id   = cmd_r.id;
            mem_wdata.dl   = cmd_r.dl;
            cnt_nxt        = cnt_r + CW'(1);
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_OK;
            res_nxt.last   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (!issue) begin
          mem_we         = 1'b1;
          mem_waddr      = '0;
          mem_wdata.id   = cmd_r.id;
          mem_wdata.dl   = cmd_r.dl;
          cnt_nxt        = cnt_r + CW'(1);
          res_nxt.valid  = 1'b1;
          res_nxt.status = ST_OK;
          res_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    ridx_r    <= ridx_nxt;
    widx_r    <= widx_nxt;
    pidx_r    <= pidx_nxt;
    pvld_r    <= pvld_nxt;
    found_r   <= found_nxt;
    pend_r    <= pend_nxt;
    pend_id_r <= pend_id_nxt;
  end

endmodule

/* sv/sorted_timer_event_queue_top.sv */
// Tick and delete: scan of N queued entries, ending in a result marked last.
// Add and modify: scan, then insertion walk if a slot is free; busy is high throughout.
// Load quantum and unused codes: result the next cycle, busy stays low.
// Fired ids stream out at most one a cycle; the receiver cannot stall them.
// Synchronous reset empties the queue and zeroes the quantum; stored words are not cleared.
module sorted_timer_event_queue_top #(
  parameter int DEPTH = steq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_deadline,
  input  logic [31:0] in_now,
  input  logic signed [15:0] in_quantum,
  output logic        out_valid,
  output logic        out_fired_valid,
  output logic [7:0]  out_fired_id,
  output logic [1:0]  out_status,
  output logic        out_resched,
  output logic        out_last
);
  import steq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic signed [15:0] quantum_r, quantum_nxt;
  logic               acc;
  logic               nonpos;
  cmd_t               cmd;
  res_t               res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  entry_t             mem_wdata, mem_rdata;

  assign acc    = start && !busy;
  assign nonpos = (quantum_r == 16'sd0) || quantum_r[15];

  always_comb begin
    quantum_nxt = quantum_r;
    if (acc) begin
      if (in_op == OP_TICK) begin
        // saturates at the most negative value
        if (quantum_r != 16'sh8000) begin
          quantum_nxt = quantum_r - 16'sd1;
        end
      end else if (in_op == OP_LOAD) begin
        quantum_nxt = in_quantum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= '0;
    end else begin
      quantum_r <= quantum_nxt;
    end
  end

  assign cmd.op      = in_op;
  assign cmd.id      = in_timer_id;
  assign cmd.dl      = in_deadline;
  assign cmd.now     = in_now;
  assign cmd.resched = nonpos;

  steq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (cmd),
    .busy      (busy),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  steq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid       = res.valid;
  assign out_fired_valid = res.fired_valid;
  assign out_fired_id    = res.fired_id;
  assign out_status      = res.status;
  assign out_resched     = res.resched;
  assign out_last        = res.last;

endmodule

/* sv/steq_checker.sv */
`include "sorted_timer_event_queue_top_assert.svh"

module steq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_fired_valid,
  input logic [1:0]  out_status,
  input logic        out_last
);
  import steq_pkg::*;

  // every accepted word either occupies the block or answers at once
  `STEQ_ASSERT_NEXT(a_acc_resp, start && !busy, busy || out_valid, "accepted word left no trace")
  // the closing result leaves the block free
  `STEQ_ASSERT_NOW(a_last_idle, out_valid && out_last, !busy, "busy after final result")
  // intermediate fired ids only come out of a running scan
  `STEQ_ASSERT_NOW(a_mid_busy, out_valid && !out_last, busy && out_fired_valid, "stray mid result")
  `STEQ_ASSERT_NOW(a_fired_ok, out_valid && out_fired_valid, out_status == ST_OK, "fired with error")

endmodule

bind sorted_timer_event_queue_top steq_checker u_steq_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import steq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam logic signed [15:0] QUANTUM_MIN = 16'sh8000;
  localparam logic signed [15:0] QUANTUM_MAX = 16'sh7fff;
  // op codes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic       fired_valid;
    logic [7:0] fired_id;
    logic [1:0] status;
    logic       resched;
    logic       last;
  } fire_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_op;
  logic [7:0]  in_timer_id;
  logic [31:0] in_deadline;
  logic [31:0] in_now;
  logic signed [15:0] in_quantum;
  logic        out_valid;
  logic        out_fired_valid;
  logic [7:0]  out_fired_id;
  logic [1:0]  out_status;
  logic        out_resched;
  logic        out_last;

  // shadow copy of the queue and the quantum counter
  logic [7:0]  shadow_ids [QDEPTH];
  logic [31:0] shadow_deadlines [QDEPTH];
  int          shadow_count = 0;
  logic signed [15:0] shadow_quantum = '0;

  fire_word_t  pending_words [$];
  int          fail_count = 0;
  int          idle_pct = 0;

  sorted_timer_event_queue_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_timer_id     (in_timer_id),
    .in_deadline     (in_deadline),
    .in_now          (in_now),
    .in_quantum      (in_quantum),
    .out_valid       (out_valid),
    .out_fired_valid (out_fired_valid),
    .out_fired_id    (out_fired_id),
    .out_status      (out_status),
    .out_resched     (out_resched),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int find_timer(input logic [7:0] id);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_timer(input int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_ids[i]       = shadow_ids[i + 1];
      shadow_deadlines[i] = shadow_deadlines[i + 1];
    end
    shadow_count--;
  endfunction

  // an id already queued is moved; equal deadlines keep arrival order
  function automatic logic [1:0] place_timer(input logic [7:0] id, input logic [31:0] dl);
    int at;
    int pos;
    at = find_timer(id);
    if (at >= 0) drop_timer(at);
    else if (shadow_count >= QDEPTH) return ST_FULL;
    pos = 0;
    while (pos < shadow_count && shadow_deadlines[pos] <= dl) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_ids[i]       = shadow_ids[i - 1];
      shadow_deadlines[i] = shadow_deadlines[i - 1];
    end
    shadow_ids[pos]       = id;
    shadow_deadlines[pos] = dl;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic void predict_queue_op(input logic [2:0] op, input logic [7:0] id,
                                           input logic [31:0] dl, input logic [31:0] now,
                                           input logic signed [15:0] q);
    int   keep;
    int   fired;
    int   at;
    logic rs;
    keep  = 0;
    fired = 0;
    case (op)
      OP_TICK: begin
        rs = (shadow_quantum <= 16'sd0);
        if (shadow_quantum != QUANTUM_MIN) shadow_quantum = shadow_quantum - 16'sd1;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_deadlines[i] <= now) begin
            pending_words.push_back('{1'b1, shadow_ids[i], ST_OK, rs, 1'b0});
            fired++;
          end else begin
            shadow_ids[keep]       = shadow_ids[i];
            shadow_deadlines[keep] = shadow_deadlines[i];
            keep++;
          end
        end
        shadow_count = keep;
        if (fired == 0) pending_words.push_back('{1'b0, 8'd0, ST_OK, rs, 1'b1});
        else pending_words[pending_words.size() - 1].last = 1'b1;
      end
      OP_ADD, OP_MOD: begin
        pending_words.push_back('{1'b0, 8'd0, place_timer(id, dl), 1'b0, 1'b1});
      end
      OP_DEL: begin
        at = find_timer(id);
        if (at >= 0) drop_timer(at);
        pending_words.push_back('{1'b0, 8'd0, (at >= 0) ? ST_OK : ST_NOTFOUND, 1'b0, 1'b1});
      end
      default: begin
        if (op == OP_LOAD) shadow_quantum = q;
        pending_words.push_back('{1'b0, 8'd0, ST_OK, 1'b0, 1'b1});
      end
    endcase
  endfunction

  // start is left high after acceptance so back-to-back words need no toggle
  task automatic send_word(input logic [2:0] op, input logic [7:0] id,
                           input logic [31:0] dl, input logic [31:0] now,
                           input logic signed [15:0] q);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_op       <= op;
    in_timer_id <= id;
    in_deadline <= dl;
    in_now      <= now;
    in_quantum  <= q;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_op(op, id, dl, now, q);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    fire_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual fv=%0b id=%0d st=%0d rs=%0b last=%0b",
                 $time, out_fired_valid, out_fired_id, out_status, out_resched, out_last);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("fired_valid", 32'(want.fired_valid), 32'(out_fired_valid));
        check_field("fired_id", 32'(want.fired_id), 32'(out_fired_id));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("resched", 32'(want.resched), 32'(out_resched));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // empty-queue ticks: zero and minimum quantum flag a reschedule, minimum saturates
  task automatic test_quantum();
    send_word(OP_LOAD, 8'd0, 32'd0, 32'd0, 16'sd0);
    send_word(OP_TICK, 8'd0, 32'd0, 32'd0, 16'sd0);
    send_word(OP_LOAD, 8'hff, 32'hffff_ffff, 32'hffff_ffff, QUANTUM_MIN);
    send_word(OP_TICK, 8'hff, 32'hffff_ffff, 32'hffff_ffff, QUANTUM_MIN);
    send_word(OP_TICK, 8'd0, 32'd0, 32'd0, 16'sd0);
    send_word(OP_LOAD, 8'd0, 32'd0, 32'd0, QUANTUM_MAX);
  endtask

  task automatic test_spare_ops();
    send_word(OP_SPARE_A, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 16'sh7fff);
    send_word(OP_SPARE_C, 8'd3, 32'd5, 32'd7, 16'sd1);
  endtask

  // fill to DEPTH with ties and extremes, probe full / absent cases, then fire all at once
  task automatic test_fill_and_fire();
    send_word(OP_ADD, 8'd0, 32'hffff_ffff, 32'd0, 16'sd0);
    send_word(OP_ADD, 8'd255, 32'd0, 32'd0, 16'sd0);
    for (int i = 1; i < QDEPTH - 1; i++) begin
      send_word(OP_ADD, 8'(i), 32'd40 + 32'(i % 3) * 32'd10, 32'd0, 16'sd0);
    end
    send_word(OP_ADD, 8'd200, 32'd1, 32'd0, 16'sd0);
    send_word(OP_MOD, 8'd201, 32'd1, 32'd0, 16'sd0);
    send_word(OP_ADD, 8'd7, 32'd0, 32'd0, 16'sd0);
    send_word(OP_DEL, 8'd201, 32'd0, 32'd0, 16'sd0);
    send_word(OP_TICK, 8'd0, 32'd0, 32'hffff_ffff, 16'sd0);
  endtask

  task automatic test_random(input int n_items, input int pct);
    logic [7:0]  pool_base;
    logic [31:0] time_base;
    logic [31:0] last_dl;
    logic [2:0]  op;
    logic [7:0]  id;
    logic [31:0] dl;
    logic [31:0] now;
    logic signed [15:0] q;
    int          sel;
    int          done;
    idle_pct  = pct;
    pool_base = 8'($urandom_range(255));
    time_base = $urandom;
    last_dl   = time_base;
    done      = 0;
    while (done < n_items) begin
      // all fields get noise; id and dl are shaped, now and q only for their op
      id  = 8'($urandom_range(255));
      dl  = $urandom;
      now = $urandom;
      q   = 16'($urandom_range(65535));
      sel = $urandom_range(99);
      if (sel < 22) op = OP_TICK;
      else if (sel < 55) op = OP_ADD;
      else if (sel < 70) op = OP_DEL;
      else if (sel < 85) op = OP_MOD;
      else if (sel < 96) op = OP_LOAD;
      else op = ($urandom_range(1) != 0) ? OP_SPARE_B : OP_SPARE_A;
      if ($urandom_range(99) < 85) id = pool_base + 8'($urandom_range(19));
      sel = $urandom_range(99);
      if (sel < 75) dl = time_base + 32'($urandom_range(60));
      else if (sel < 87) dl = last_dl;
      if (op == OP_ADD || op == OP_MOD) last_dl = dl;
      if (op == OP_TICK && $urandom_range(99) < 90) begin
        time_base = time_base + 32'($urandom_range(20));
        now = time_base;
      end
      if (op == OP_LOAD && $urandom_range(1) != 0) q = 16'sd5 - 16'($urandom_range(7));
      send_word(op, id, dl, now, q);
      if (op <= OP_LOAD) done++;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_op       <= OP_TICK;
    in_timer_id <= '0;
    in_deadline <= '0;
    in_now      <= '0;
    in_quantum  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quantum();
    test_spare_ops();
    test_fill_and_fire();
    test_random(43, 0);
    test_random(43, 63);
    test_random(43, 8);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2 * QDEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
